// File: rtl/core/wlr_pkg.sv
// ---------------------------------------------------------------------------
// wlr_pkg - shared definitions for the wear-levelled record ring
// Widths, reset values, command and register codes, and the CRC-16 byte step
// (reflected polynomial 0xA001) used on both the write and read paths.
// ---------------------------------------------------------------------------
package wlr_pkg;

  // Fixed widths
  localparam int IDX_W  = 16;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int SCNT_W = 4;   // slot_count register
  localparam int RBYT_W = 5;   // record_bytes register
  localparam int CFGD_W = 5;   // widest configuration register
  localparam int OSLT_W = 3;   // slot field on the result channel

  // Default sizing of the store
  localparam int DEF_MAX_SLOTS  = 8;
  localparam int DEF_MAX_RECORD = 16;

  // Register indexes
  localparam logic CFG_SLOT_COUNT   = 1'b0;
  localparam logic CFG_RECORD_BYTES = 1'b1;

  // Commands and result kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Reset values
  localparam logic [SCNT_W-1:0] RST_SLOT_COUNT   = 4'd4;
  localparam logic [RBYT_W-1:0] RST_RECORD_BYTES = 5'd16;
  localparam logic [IDX_W-1:0]  RST_INDEX        = 16'd1;
  localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY         = 16'hA001;
  localparam logic [BYTE_W-1:0] ERASED_BYTE      = 8'hFF;

  // One byte folded into a reflected CRC-16, eight shift steps
  function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/wear_leveled_record_ring_crc.sv
// ---------------------------------------------------------------------------
// wear_leveled_record_ring_crc - wear-levelled record ring with CRC-16
// One record is written in turn into a ring of slots of a byte store; each
// write folds the record into a CRC-16, checked on multi-slot read-back.
//
//   channel  direction  beat
//   in_      input      cmd, data_byte: one record byte or a read request
//   out_     output     kind, rec_byte, last, crc_ok, slot, record_index
//   cfg_     input      write enable, register index, data (no handshake)
//
// A read returns record_bytes beats, one per cycle from the store's read port
// while the output register is free, and the next item is taken only once
// the last data beat has moved into the output register. After reset the
// store is swept to 0xFF over all MAX_SLOTS*MAX_RECORD bytes. After reset
// and after each configuration write the slot position is recomputed, and
// input is held off until it has landed. Input is also held off whenever
// the output register is full and not being taken.
// ---------------------------------------------------------------------------
module wear_leveled_record_ring_crc
  import wlr_pkg::*;
#(
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int MAX_RECORD = DEF_MAX_RECORD
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [BYTE_W-1:0] in_data_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [BYTE_W-1:0] out_rec_byte,
  output logic              out_last,
  output logic              out_crc_ok,
  output logic [OSLT_W-1:0] out_slot,
  output logic [IDX_W-1:0]  out_record_index,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFGD_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_SLOTS * MAX_RECORD;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int POS_W  = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
  localparam int CNT_W  = $clog2(MAX_RECORD + 1);
  localparam int NW     = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  // Byte store
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q_r;

  // Control and record state
  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [SCNT_W-1:0] slot_count_r;
  logic [RBYT_W-1:0] record_bytes_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CRC_W-1:0]  committed_crc_r;
  logic              fresh_r;
  logic [POS_W-1:0]  wpos_r;
  logic [CRC_W-1:0]  run_crc_r;
  logic [SLOT_W-1:0] wr_slot_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic              mod_start_r;
  logic [CNT_W-1:0]  iss_cnt_r;
  logic [CNT_W-1:0]  mv_cnt_r;
  logic              pend_r;
  logic [CRC_W-1:0]  rd_crc_r;

  // Output register
  logic              out_valid_r;
  logic              out_kind_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_ok_r;
  logic [OSLT_W-1:0] out_slot_r;
  logic [IDX_W-1:0]  out_idx_r;

  // Combinational
  logic [NW-1:0]     n_eff;
  logic [CNT_W-1:0]  rb_eff;
  logic              multi;
  logic              in_fire, wr_fire, rd_fire;
  logic              out_free;
  logic              wr_last;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CRC_W-1:0]  crc_nxt;
  logic              rd_issue, rd_move, rd_last, rd_ok;
  logic [CRC_W-1:0]  rd_crc_nxt;
  logic [IDX_W-1:0]  idx_inc;
  logic [SLOT_W-1:0] wr_slot_nxt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mod_busy, mod_done;
  logic [SLOT_W-1:0] mod_rem_cur, mod_rem_prev;

  // Effective configuration, clamped to the legal range
  always_comb begin
    if (slot_count_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(slot_count_r) > 32'(MAX_SLOTS)) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(slot_count_r);
    end
    if (record_bytes_r == '0) begin
      rb_eff = CNT_W'(1);
    end else if (32'(record_bytes_r) > 32'(MAX_RECORD)) begin
      rb_eff = CNT_W'(MAX_RECORD);
    end else begin
      rb_eff = CNT_W'(record_bytes_r);
    end
  end

  assign multi = (n_eff > NW'(1));

  // Handshake; held off until the slot position has landed
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !mod_start_r && !mod_busy && !mod_done
                    && out_free;
  assign in_fire  = in_valid && in_ready;
  assign wr_fire  = in_fire && (in_cmd == CMD_WRITE);
  assign rd_fire  = in_fire && (in_cmd == CMD_READ);

  // Write path
  assign wr_last = (CNT_W'(wpos_r) + CNT_W'(1)) >= rb_eff;
  assign wr_addr = ADDR_W'(wr_slot_r) * ADDR_W'(MAX_RECORD) + ADDR_W'(wpos_r);
  assign crc_nxt = crc16_fold(run_crc_r, in_data_byte);
  assign idx_inc = idx_r + IDX_W'(1);

  // Next write slot after a commit; the index wrap lands on slot zero
  always_comb begin
    if (idx_inc == '0) begin
      wr_slot_nxt = '0;
    end else if ((NW'(wr_slot_r) + NW'(1)) == n_eff) begin
      wr_slot_nxt = '0;
    end else begin
      wr_slot_nxt = wr_slot_r + SLOT_W'(1);
    end
  end

  // Read path: issue an address, hold the data until the output takes it
  assign rd_move    = pend_r && out_free;
  assign rd_issue   = (state_r == ST_READ) && (iss_cnt_r < rb_eff) && (!pend_r || rd_move);
  assign rd_addr    = ADDR_W'(rd_slot_r) * ADDR_W'(MAX_RECORD)
                    + ADDR_W'(iss_cnt_r[POS_W-1:0]);
  assign rd_last    = (mv_cnt_r == (rb_eff - CNT_W'(1)));
  assign rd_crc_nxt = crc16_fold(rd_crc_r, mem_q_r);
  assign rd_ok      = !multi || fresh_r || (rd_crc_nxt == committed_crc_r);

  // Store write port: clearing sweep or record byte
  assign mem_we    = (state_r == ST_CLEAR) || wr_fire;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr;
  assign mem_wdata = (state_r == ST_CLEAR) ? ERASED_BYTE : in_data_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_issue) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Slot position from the index
  wlr_slot_mod #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slot_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start_r),
    .idx      (idx_r),
    .n        (n_eff),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem_cur  (mod_rem_cur),
    .rem_prev (mod_rem_prev)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rd_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_move && rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_addr_r      <= '0;
      slot_count_r    <= RST_SLOT_COUNT;
      record_bytes_r  <= RST_RECORD_BYTES;
      idx_r           <= RST_INDEX;
      committed_crc_r <= '0;
      fresh_r         <= 1'b1;
      wpos_r          <= '0;
      run_crc_r       <= CRC_INIT;
      wr_slot_r       <= '0;
      rd_slot_r       <= '0;
      mod_start_r     <= 1'b1;
      iss_cnt_r       <= '0;
      mv_cnt_r        <= '0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_start_r <= 1'b0;

      // clearing sweep
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end

      // slot position ready
      if (mod_done) begin
        wr_slot_r <= mod_rem_cur;
        rd_slot_r <= mod_rem_prev;
      end

      // record byte written; the final byte commits
      if (wr_fire) begin
        if (wr_last) begin
          wpos_r    <= '0;
          run_crc_r <= CRC_INIT;
          if (multi) begin
            committed_crc_r <= crc_nxt;
            idx_r           <= idx_inc;
            fresh_r         <= 1'b0;
            rd_slot_r       <= wr_slot_r;
            wr_slot_r       <= wr_slot_nxt;
          end
        end else begin
          wpos_r    <= wpos_r + POS_W'(1);
          run_crc_r <= crc_nxt;
        end
      end

      // read sequencing
      if (rd_fire) begin
        iss_cnt_r <= '0;
        mv_cnt_r  <= '0;
        rd_crc_r  <= CRC_INIT;
      end
      if (rd_issue) begin
        iss_cnt_r <= iss_cnt_r + CNT_W'(1);
      end
      if (rd_move) begin
        mv_cnt_r <= mv_cnt_r + CNT_W'(1);
        rd_crc_r <= rd_crc_nxt;
      end
      if (rd_issue) begin
        pend_r <= 1'b1;
      end else if (rd_move) begin
        pend_r <= 1'b0;
      end

      // output register occupancy
      if ((wr_fire && wr_last) || rd_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // configuration write abandons a partial record
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_COUNT:   slot_count_r   <= cfg_wdata[SCNT_W-1:0];
          CFG_RECORD_BYTES: record_bytes_r <= cfg_wdata[RBYT_W-1:0];
          default:          slot_count_r   <= slot_count_r;
        endcase
        wpos_r      <= '0;
        run_crc_r   <= CRC_INIT;
        mod_start_r <= 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (wr_fire && wr_last) begin
      out_kind_r <= KIND_ACK;
      out_byte_r <= '0;
      out_last_r <= 1'b1;
      out_ok_r   <= 1'b0;
      out_slot_r <= OSLT_W'(wr_slot_r);
      out_idx_r  <= multi ? idx_inc : idx_r;
    end else if (rd_move) begin
      out_kind_r <= KIND_DATA;
      out_byte_r <= mem_q_r;
      out_last_r <= rd_last;
      out_ok_r   <= rd_last && rd_ok;
      out_slot_r <= OSLT_W'(rd_slot_r);
      out_idx_r  <= idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_rec_byte     = out_byte_r;
  assign out_last         = out_last_r;
  assign out_crc_ok       = out_ok_r;
  assign out_slot         = out_slot_r;
  assign out_record_index = out_idx_r;

endmodule

// File: rtl/core/wlr_slot_mod.sv
// ---------------------------------------------------------------------------
// wlr_slot_mod - ring slot position from the record index
// Restoring remainder, one dividend bit per cycle, giving index mod n and
// (index - 1) mod n together.
// ---------------------------------------------------------------------------
module wlr_slot_mod
  import wlr_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [IDX_W-1:0]               idx,
  input  logic [$clog2(MAX_SLOTS+1)-1:0] n,
  output logic                           busy,
  output logic                           done,
  output logic [$clog2(MAX_SLOTS)-1:0]   rem_cur,
  output logic [$clog2(MAX_SLOTS)-1:0]   rem_prev
);

  localparam int NW     = $clog2(MAX_SLOTS + 1);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int STEP_W = $clog2(IDX_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [IDX_W-1:0]  dvd_cur_r;
  logic [IDX_W-1:0]  dvd_prev_r;
  logic [NW-1:0]     rcur_r;
  logic [NW-1:0]     rprev_r;
  logic [NW-1:0]     div_r;

  logic [NW:0]       sh_cur;
  logic [NW:0]       sh_prev;
  logic [NW-1:0]     rcur_nxt;
  logic [NW-1:0]     rprev_nxt;

  // Shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    sh_cur  = {rcur_r, dvd_cur_r[IDX_W-1]};
    sh_prev = {rprev_r, dvd_prev_r[IDX_W-1]};
    if (sh_cur >= {1'b0, div_r}) begin
      rcur_nxt = NW'(sh_cur - {1'b0, div_r});
    end else begin
      rcur_nxt = NW'(sh_cur);
    end
    if (sh_prev >= {1'b0, div_r}) begin
      rprev_nxt = NW'(sh_prev - {1'b0, div_r});
    end else begin
      rprev_nxt = NW'(sh_prev);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(IDX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_cur_r  <= idx;
      dvd_prev_r <= idx - IDX_W'(1);
      div_r      <= n;
      rcur_r     <= '0;
      rprev_r    <= '0;
    end else if (busy_r) begin
      dvd_cur_r  <= dvd_cur_r << 1;
      dvd_prev_r <= dvd_prev_r << 1;
      rcur_r     <= rcur_nxt;
      rprev_r    <= rprev_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign rem_cur  = SLOT_W'(rcur_r);
  assign rem_prev = SLOT_W'(rprev_r);

endmodule

// File: tb/sv/tb_wear_leveled_record_ring_crc.sv
// ---------------------------------------------------------------------------
// tb_wear_leveled_record_ring_crc - self-checking bench for the record ring
// A tracker class keeps its own copy of the byte store, the record index and
// the CRC-16 state. It works out every acknowledge and read-back beat the
// block owes. The bench runs directed corner cases first: erased store,
// single slot, clamped register values, a read inside a partial write, an
// abandoned partial write and a CRC mismatch. It then runs random record
// traffic over a range of register settings, with the sender and receiver
// stalling in turn, and finally a short run of single-byte records over
// five slots with a read after each commit.
// ---------------------------------------------------------------------------
module tb_wear_leveled_record_ring_crc;
  import wlr_pkg::*;

  localparam int STORE_DEPTH  = DEF_MAX_SLOTS * DEF_MAX_RECORD;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 32;
  localparam int NUM_PHASES   = 9;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] rec_byte;
    logic              last;
    logic              crc_ok;
    logic [OSLT_W-1:0] slot;
    logic [IDX_W-1:0]  record_index;
  } ring_beat_t;

  // Tracks the ring state and the result beats still owed by the block
  class record_ring_tracker;
    logic [BYTE_W-1:0] store [0:STORE_DEPTH-1];
    logic [IDX_W-1:0]  rec_idx;
    logic [CRC_W-1:0]  saved_crc;
    logic [CRC_W-1:0]  run_crc;
    bit                fresh;
    int                wr_pos;
    logic [SCNT_W-1:0] slot_reg;
    logic [RBYT_W-1:0] bytes_reg;
    ring_beat_t        owed_results[$];
    int                faults;

    function new();
      foreach (store[i]) store[i] = ERASED_BYTE;
      rec_idx   = RST_INDEX;
      saved_crc = '0;
      run_crc   = CRC_INIT;
      fresh     = 1'b1;
      wr_pos    = 0;
      slot_reg  = RST_SLOT_COUNT;
      bytes_reg = RST_RECORD_BYTES;
      faults    = 0;
    endfunction

    // Reflected CRC-16, LSB first
    function logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
      logic lsb;
      c[BYTE_W-1:0] = c[BYTE_W-1:0] ^ b;
      for (int k = 0; k < 8; k++) begin
        lsb = c[0];
        c = {1'b0, c[CRC_W-1:1]};
        if (lsb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    // Register values clamp into the legal range
    function int eff_slots();
      if (slot_reg == 0) return 1;
      if (slot_reg > DEF_MAX_SLOTS) return DEF_MAX_SLOTS;
      return int'(slot_reg);
    endfunction

    function int eff_bytes();
      if (bytes_reg == 0) return 1;
      if (bytes_reg > DEF_MAX_RECORD) return DEF_MAX_RECORD;
      return int'(bytes_reg);
    endfunction

    // A register write drops any record in progress
    function void set_reg(logic idx, logic [CFGD_W-1:0] value);
      if (idx == CFG_SLOT_COUNT) slot_reg = value[SCNT_W-1:0];
      else bytes_reg = value[RBYT_W-1:0];
      wr_pos  = 0;
      run_crc = CRC_INIT;
    endfunction

    // One accepted input beat: update state, queue the beats it causes
    function void note_command(logic cmd, logic [BYTE_W-1:0] data);
      int               n;
      int               rb;
      int               pos;
      int               s;
      logic [IDX_W-1:0] prev;
      logic [CRC_W-1:0] crc;
      ring_beat_t       beat;
      n  = eff_slots();
      rb = eff_bytes();
      if (cmd == CMD_WRITE) begin
        s   = (n > 1) ? int'(rec_idx % n) : 0;
        pos = (wr_pos >= rb) ? rb - 1 : wr_pos;
        store[s * DEF_MAX_RECORD + pos] = data;
        run_crc = fold_byte(run_crc, data);
        if (pos + 1 < rb) begin
          wr_pos = pos + 1;
          return;
        end
        // last byte of the record: commit, single slot keeps index and CRC
        if (n > 1) begin
          saved_crc = run_crc;
          rec_idx   = rec_idx + 1'b1;
          fresh     = 1'b0;
        end
        wr_pos  = 0;
        run_crc = CRC_INIT;
        beat.kind         = KIND_ACK;
        beat.rec_byte     = '0;
        beat.last         = 1'b1;
        beat.crc_ok       = 1'b0;
        beat.slot         = s[OSLT_W-1:0];
        beat.record_index = rec_idx;
        owed_results.push_back(beat);
      end else begin
        prev = rec_idx - 1'b1;
        s    = (n > 1) ? int'(prev % n) : 0;
        crc  = CRC_INIT;
        for (int p = 0; p < rb; p++) begin
          beat.kind         = KIND_DATA;
          beat.rec_byte     = store[s * DEF_MAX_RECORD + p];
          beat.last         = (p == rb - 1);
          beat.crc_ok       = 1'b0;
          beat.slot         = s[OSLT_W-1:0];
          beat.record_index = rec_idx;
          crc = fold_byte(crc, beat.rec_byte);
          if (p == rb - 1) beat.crc_ok = (n <= 1) || fresh || (crc == saved_crc);
          owed_results.push_back(beat);
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        faults++;
      end
    endfunction

    // One result beat against the oldest owed beat
    function void check_result(ring_beat_t got);
      ring_beat_t want;
      if (owed_results.size() == 0) begin
        $error("result beat with nothing outstanding");
        faults++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("rec_byte", want.rec_byte, got.rec_byte);
      compare_field("last", want.last, got.last);
      compare_field("crc_ok", want.crc_ok, got.crc_ok);
      compare_field("slot", want.slot, got.slot);
      compare_field("record_index", want.record_index, got.record_index);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_cmd = CMD_WRITE;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  logic [BYTE_W-1:0] out_rec_byte;
  logic              out_last;
  logic              out_crc_ok;
  logic [OSLT_W-1:0] out_slot;
  logic [IDX_W-1:0]  out_record_index;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_SLOT_COUNT;
  logic [CFGD_W-1:0] cfg_wdata = '0;

  record_ring_tracker ring;
  ring_beat_t         seen_beat;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 quiet_cycles = 0;

  wear_leveled_record_ring_crc u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_rec_byte     (out_rec_byte),
    .out_last         (out_last),
    .out_crc_ok       (out_crc_ok),
    .out_slot         (out_slot),
    .out_record_index (out_record_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: results checked before the same edge's input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_beat.kind         = out_kind;
        seen_beat.rec_byte     = out_rec_byte;
        seen_beat.last         = out_last;
        seen_beat.crc_ok       = out_crc_ok;
        seen_beat.slot         = out_slot;
        seen_beat.record_index = out_record_index;
        ring.check_result(seen_beat);
      end
      if (in_valid && in_ready) ring.note_command(in_cmd, in_data_byte);
    end
    // watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL wear_leveled_record_ring_crc");
      $finish;
    end
  end

  // Offer one beat, with a random gap first, and wait for it to be taken
  task automatic send_beat(input logic cmd, input logic [BYTE_W-1:0] data);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering, let every owed beat arrive, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (ring.owed_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFGD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Mostly whole records with random bytes, some reads and stray bytes
  task automatic run_phase(input int budget);
    int sent;
    int rb;
    int len;
    int pick;
    sent = 0;
    rb   = ring.eff_bytes();
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = rb;
      else if (pick < 8) len = 0;
      else len = $urandom_range(1, rb);
      if (len == 0) begin
        send_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        repeat (len) begin
          send_beat(CMD_WRITE, BYTE_W'($urandom_range(0, 255)));
          sent++;
        end
      end
      if (pick < 6 && $urandom_range(0, 1) == 1) begin
        send_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)));
        sent++;
      end
    end
    settle();
  endtask

  int phase_slots [NUM_PHASES] = '{3, 8, 1, 15, 0, 2, 5, 7, 4};
  int phase_bytes [NUM_PHASES] = '{4, 1, 5, 31, 0, 7, 3, 16, 16};

  initial begin
    ring = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // erased store reads back as valid before any commit
    send_beat(CMD_READ, 8'h00);
    settle();

    // single slot: no CRC, index stays put
    write_reg(CFG_SLOT_COUNT, 5'd1);
    write_reg(CFG_RECORD_BYTES, 5'd1);
    send_beat(CMD_WRITE, 8'h00);
    send_beat(CMD_READ, 8'hFF);
    settle();

    // zero in both registers clamps to one
    write_reg(CFG_SLOT_COUNT, 5'd0);
    write_reg(CFG_RECORD_BYTES, 5'd0);
    send_beat(CMD_WRITE, 8'hFF);
    send_beat(CMD_READ, 8'h00);
    settle();

    // slot count above range clamps to eight; read inside a partial write
    write_reg(CFG_SLOT_COUNT, 5'h1F);
    write_reg(CFG_RECORD_BYTES, 5'd2);
    send_beat(CMD_WRITE, 8'hA5);
    send_beat(CMD_READ, 8'h55);
    send_beat(CMD_WRITE, 8'h5A);
    send_beat(CMD_READ, 8'hAA);
    settle();

    // a register write abandons the half-written record
    send_beat(CMD_WRITE, 8'h3C);
    settle();
    write_reg(CFG_RECORD_BYTES, 5'd3);
    send_beat(CMD_WRITE, 8'h01);
    send_beat(CMD_WRITE, 8'h80);
    send_beat(CMD_WRITE, 8'h7F);
    send_beat(CMD_READ, 8'h00);
    settle();

    // longer record than committed: CRC no longer matches
    write_reg(CFG_RECORD_BYTES, 5'd4);
    send_beat(CMD_READ, 8'h00);
    settle();
    write_reg(CFG_RECORD_BYTES, 5'd31);
    send_beat(CMD_READ, 8'h00);
    settle();

    // random traffic; receiver-heavy stalls, then sender-heavy, then none
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_SLOT_COUNT, CFGD_W'(phase_slots[ph]));
      write_reg(CFG_RECORD_BYTES, CFGD_W'(phase_bytes[ph]));
      run_phase(PHASE_ITEMS);
    end

    // single-byte records over five slots, each commit read straight back
    write_reg(CFG_SLOT_COUNT, 5'd5);
    write_reg(CFG_RECORD_BYTES, 5'd1);
    repeat (6) begin
      send_beat(CMD_WRITE, BYTE_W'($urandom_range(0, 255)));
      send_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)));
    end
    settle();

    if (ring.faults == 0) begin
      $display("PASS wear_leveled_record_ring_crc");
    end else begin
      $display("FAIL wear_leveled_record_ring_crc");
    end
    $finish;
  end

endmodule
